@@ design/sorted_array_priority_queue_macros.svh @@
// ----------------------------------------------------------------------------
// Sorted array priority queue: assertion macros
// Concurrent assertion wrappers. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
// checked while out of reset
`define SAPQ_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sorted array priority queue: assertion failed");
// checked on every edge, reset included
`define SAPQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sorted array priority queue: assertion failed");
`else
`define SAPQ_ASSERT(label, clk, rstn, prop)
`define SAPQ_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ design/sapq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted array priority queue: package
// Sizes, operation and status codes, item types and the compare result.
// ----------------------------------------------------------------------------
package sapq_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic                     func;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic        [1:0]         status;
    logic        [COUNT_W-1:0] count;
    logic signed [DATA_W-1:0]  head_value;
  } out_t;

  typedef struct packed {
    logic ge;
    logic eq;
  } cmp_t;

endpackage

@@ design/sapq_cmp.sv @@
// ----------------------------------------------------------------------------
// Sorted array priority queue: compare unit
// Signed greater-or-equal and equality of the item value against one entry.
// ----------------------------------------------------------------------------
module sapq_cmp import sapq_pkg::*; (
  input  logic signed [DATA_W-1:0] a_i,
  input  logic signed [DATA_W-1:0] b_i,
  output cmp_t                     cmp_o
);

  assign cmp_o.ge = (a_i >= b_i);
  assign cmp_o.eq = (a_i == b_i);

endmodule

@@ design/sorted_array_priority_queue.sv @@
// ----------------------------------------------------------------------------
// Sorted array priority queue
// Up to DEPTH signed words kept in descending order in a single-port-write,
// registered-read array, walked one entry a cycle through one compare unit.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+-----------------
//   in      | in_valid_i | in_stall_o  | in_data_i  (in_t)
//   out     | out_valid_o| out_stall_i | out_data_o (out_t)
//
// Insert walks from the tail, shifting entries down until the slot is found.
// Delete walks from the head, shifting up behind the match. Full, empty and
// first insert go straight to the result state. The input is stalled while
// an item is in progress. Reset leaves the queue empty; stored words have no
// reset. A stalled output holds its item and the result of the following
// item waits until the output register frees.
// ----------------------------------------------------------------------------
`include "sorted_array_priority_queue_macros.svh"

module sorted_array_priority_queue import sapq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_DEL  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_q, state_d;
  cnt_t       occ_q, occ_d;
  idx_t       k_q, k_d;
  logic       found_q, found_d;
  logic       out_valid_q, out_valid_d;
  out_t       out_data_q, out_data_d;
  logic [1:0] status_q, status_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  logic signed [DATA_W-1:0] head_q, head_d;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;
  logic                     mem_we;
  idx_t                     mem_waddr, mem_raddr;
  logic signed [DATA_W-1:0] mem_wdata;

  cnt_t occ_m1;
  logic last;
  logic hit;
  cmp_t cmp;

  sapq_cmp u_cmp (
    .a_i   (value_q),
    .b_i   (rdata_q),
    .cmp_o (cmp)
  );

  assign occ_m1 = occ_q - cnt_t'(1);
  assign last   = (cnt_t'(k_q) == occ_m1);
  assign hit    = found_q | cmp.eq;

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    k_d         = k_q;
    found_d     = found_q;
    status_d    = status_q;
    value_d     = value_q;
    head_d      = head_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = value_q;
    mem_raddr   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          value_d = in_data_i.value;
          if (in_data_i.func == FUNC_INSERT) begin
            if (occ_q == cnt_t'(DEPTH)) begin
              status_d = ST_FULL;
              state_d  = S_FIN;
            end else if (occ_q == '0) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = in_data_i.value;
              head_d    = in_data_i.value;
              occ_d     = cnt_t'(1);
              status_d  = ST_OK;
              state_d   = S_FIN;
            end else begin
              k_d       = occ_q[IDX_W-1:0];
              mem_raddr = occ_m1[IDX_W-1:0];
              state_d   = S_INS;
            end
          end else begin
            if (occ_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_FIN;
            end else begin
              k_d       = '0;
              found_d   = 1'b0;
              mem_raddr = '0;
              state_d   = S_DEL;
            end
          end
        end
      end
      S_INS: begin
        // rdata_q holds entry k_q - 1
        if (k_q == '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = value_q;
          head_d    = value_q;
          occ_d     = occ_q + cnt_t'(1);
          status_d  = ST_OK;
          state_d   = S_FIN;
        end else if (cmp.ge) begin
          mem_we    = 1'b1;
          mem_waddr = k_q;
          mem_wdata = rdata_q;
          k_d       = k_q - idx_t'(1);
          mem_raddr = k_q - idx_t'(2);
        end else begin
          mem_we    = 1'b1;
          mem_waddr = k_q;
          mem_wdata = value_q;
          occ_d     = occ_q + cnt_t'(1);
          status_d  = ST_OK;
          state_d   = S_FIN;
        end
      end
      S_DEL: begin
        // rdata_q holds entry k_q
        if (found_q) begin
          mem_we    = 1'b1;
          mem_waddr = k_q - idx_t'(1);
          mem_wdata = rdata_q;
          if (k_q == idx_t'(1)) begin
            head_d = rdata_q;
          end
        end
        found_d   = hit;
        k_d       = k_q + idx_t'(1);
        mem_raddr = k_q + idx_t'(1);
        if (last) begin
          state_d = S_FIN;
          if (hit) begin
            occ_d    = occ_m1;
            status_d = ST_OK;
          end else begin
            status_d = ST_NOTFOUND;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d           = 1'b1;
          out_data_d.status     = status_q;
          out_data_d.count      = COUNT_W'(occ_q);
          out_data_d.head_value = (occ_q != '0) ? head_q : '0;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      k_q         <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      k_q         <= k_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    value_q    <= value_d;
    head_q     <= head_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `SAPQ_ASSERT_ALWAYS(a_occ_bound, clk_i, !rst_ni || (occ_q <= cnt_t'(DEPTH)))
  `SAPQ_ASSERT(a_occ_step, clk_i, rst_ni, !$stable(occ_q) |-> (($past(occ_q) + cnt_t'(1) == occ_q) || (occ_q + cnt_t'(1) == $past(occ_q))))
  `SAPQ_ASSERT(a_full_count, clk_i, rst_ni, (out_valid_q && out_data_q.status == ST_FULL) |-> (out_data_q.count == COUNT_W'(DEPTH)))
  `SAPQ_ASSERT(a_fin_load, clk_i, rst_ni, (state_q == S_FIN && (!out_valid_q || !out_stall_i)) |=> (out_valid_q && state_q == S_IDLE))

endmodule
